/* sv/rgbhsl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSL package
// Shared widths, sector codes and the front-to-back word type.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

    localparam int HueSector = 3840;
    localparam int HueFull   = 23040;
    localparam int HueW      = 15;
    localparam int SatW      = 16;
    localparam int LitW      = 9;
    // numerator: up to 23040*255 < 2^23
    localparam int NumW      = 23;
    // divider bits: hue quotient 15 bits, sat quotient 17 bits
    localparam int HueQW     = 15;
    localparam int SatQW     = 17;
    localparam int SatNumW   = 24;

    typedef enum logic [1:0] {
        SECT_RED   = 2'd0,
        SECT_GREEN = 2'd1,
        SECT_BLUE  = 2'd2
    } sector_t;

    // classified word handed from front to back
    typedef struct packed {
        logic [NumW-1:0]    hue_num;
        logic [7:0]         delta;
        logic [8:0]         denom;
        logic [LitW-1:0]    light;
    } cls_word_t;

endpackage

/* sv/rgb_to_hsl_converter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSL converter
// 8-bit RGB pixel in, fixed-point hue, saturation and lightness out.
// ----------------------------------------------------------------------------
//  channel | signals                        | width
//  pixel   | valid, stall, red green blue   | 8 each
//  hsl     | out_valid, out_stall, hue sat l| 15/16/9
//
// One pixel per clock sustained while out_stall is low. Path: 1 front stage,
// the 2-entry queue, an entry stage and 9 divider stages (two quotient
// bits each). Reset clears only valid flags, queue pointers and queue count.
// A stall at the output backs up through the divider, then queue, then front.
module rgb_to_hsl_converter
    import rgbhsl_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            valid,
    output logic            stall,
    input  logic [7:0]      red,
    input  logic [7:0]      green,
    input  logic [7:0]      blue,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [HueW-1:0] hue,
    output logic [SatW-1:0] saturation,
    output logic [LitW-1:0] lightness
);

    logic      f_valid, f_stall, q_valid, q_stall;
    cls_word_t f_word, q_word;

    rgbhsl_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(valid), .in_stall(stall),
        .red(red), .green(green), .blue(blue),
        .out_valid(f_valid), .out_stall(f_stall), .out_word(f_word)
    );

    rgbhsl_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .in_valid(f_valid), .in_stall(f_stall), .in_word(f_word),
        .out_valid(q_valid), .out_stall(q_stall), .out_word(q_word)
    );

    rgbhsl_back u_back (
        .clk(clk), .rst_n(rst_n),
        .in_valid(q_valid), .in_stall(q_stall), .in_word(q_word),
        .out_valid(out_valid), .out_stall(out_stall),
        .hue(hue), .saturation(saturation), .lightness(lightness)
    );

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hue < HueW'(HueFull))
        else $error("hue out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hue) && $stable(lightness))
        else $error("result changed under stall");

    // zero saturation only for a gray pixel, which has zero hue
    a_gray: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturation == '0 |-> hue == '0)
        else $error("gray check");

    a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid && f_stall |=> f_valid && $stable(f_word))
        else $error("front word changed while queue full");

endmodule

/* sv/rgbhsl_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSL front
// Finds max, min, delta and sector, forms the hue numerator and the
// saturation denominator; one registered stage with skid-free hold.
// ----------------------------------------------------------------------------
module rgbhsl_front
    import rgbhsl_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [7:0]      red,
    input  logic [7:0]      green,
    input  logic [7:0]      blue,
    output logic            out_valid,
    input  logic            out_stall,
    output cls_word_t       out_word
);

    logic       valid_reg;
    cls_word_t  word_reg;
    cls_word_t  word_next;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] dlt;
    logic [8:0] light;
    sector_t    sect;
    logic signed [9:0]  diff;
    logic signed [24:0] n;
    logic       load;

    always_comb
    begin
        hi = (red > green) ? red : green;
        hi = (hi > blue) ? hi : blue;
        lo = (red < green) ? red : green;
        lo = (lo < blue) ? lo : blue;
        dlt = hi - lo;
        light = {1'b0, hi} + {1'b0, lo};
        if (red > green)
            sect = (red > blue) ? SECT_RED : SECT_BLUE;
        else
            sect = (green > blue) ? SECT_GREEN : SECT_BLUE;
        case (sect)
            SECT_RED:   diff = $signed({2'b00, green}) - $signed({2'b00, blue});
            SECT_GREEN: diff = $signed({2'b00, blue}) - $signed({2'b00, red});
            default:    diff = $signed({2'b00, red}) - $signed({2'b00, green});
        endcase
        // 3840 = 15 << 8: shift-add
        n = ((25'(diff) <<< 12) - (25'(diff) <<< 8));
        case (sect)
            SECT_RED:   n = n;
            SECT_GREEN: n = n + 25'(dlt) * 25'(2 * HueSector);
            default:    n = n + 25'(dlt) * 25'(4 * HueSector);
        endcase
        if (n < 0)
            n = n + 25'(dlt) * 25'(HueFull);
        if (dlt == 8'd0)
            n = '0;
        word_next.hue_num = n[NumW-1:0];
        word_next.delta   = dlt;
        word_next.denom   = (light <= 9'd255) ? light : (9'd510 - light);
        word_next.light   = light;
    end

    assign in_stall = valid_reg && out_stall;
    assign load     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!in_stall)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

/* sv/rgbhsl_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSL queue
// Two-entry queue between front and back; full-rate with registered flags.
// ----------------------------------------------------------------------------
module rgbhsl_fifo
    import rgbhsl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  cls_word_t   in_word,
    output logic        out_valid,
    input  logic        out_stall,
    output cls_word_t   out_word
);

    cls_word_t  mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign in_stall  = (cnt_reg == 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign push      = in_valid && !in_stall;
    assign pop       = out_valid && !out_stall;
    assign out_word  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= in_word;
    end

endmodule

/* sv/rgbhsl_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSL back
// Pipelined restoring dividers: hue numerator / delta and
// (delta << 16) / denom, two quotient bits per stage, shared stall.
// ----------------------------------------------------------------------------
module rgbhsl_back
    import rgbhsl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  cls_word_t           in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [HueW-1:0]     hue,
    output logic [SatW-1:0]     saturation,
    output logic [LitW-1:0]     lightness
);

    localparam int BitsPerStage = 2;
    localparam int Stages       = (SatQW + BitsPerStage - 1) / BitsPerStage;
    // the hue quotient is shorter: it begins after the first stage
    localparam int HueSkip      = SatQW - HueQW;

    // partial remainders kept in numerator-width shift registers
    logic [NumW-1:0]    hrem_reg  [Stages+1];
    logic [SatNumW:0]   srem_reg  [Stages+1];
    logic [7:0]         dlt_reg   [Stages+1];
    logic [8:0]         den_reg   [Stages+1];
    logic [LitW-1:0]    lit_reg   [Stages+1];
    logic [Stages:0]    vld_reg;
    logic [Stages:0]    adv;

    // word: [22:15] remainder, [14:0] numerator bits becoming quotient
    function automatic logic [NumW-1:0] hstep(input logic [NumW-1:0] w,
                                              input logic [7:0] d);
        logic [8:0] r;
        r = {w[NumW-1 -: 8], w[HueQW-1]};
        if (r >= {1'b0, d})
            return {8'(r - {1'b0, d}), w[HueQW-2:0], 1'b1};
        else
            return {r[7:0], w[HueQW-2:0], 1'b0};
    endfunction

    // word: [24:17] remainder, [16:0] numerator/quotient
    function automatic logic [SatNumW:0] sstep(input logic [SatNumW:0] w,
                                               input logic [8:0] d);
        logic [8:0] r;
        r = {w[SatNumW -: 8], w[SatQW-1]};
        if (r >= d)
            return {8'(r - d), w[SatQW-2:0], 1'b1};
        else
            return {r[7:0], w[SatQW-2:0], 1'b0};
    endfunction

    // stage 0 is the entry register
    always_comb
    begin
        adv[Stages] = !(vld_reg[Stages] && out_stall);
        for (int s = Stages - 1; s >= 0; s--)
            adv[s] = !vld_reg[s] || adv[s+1];
    end
    assign in_stall = !adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (adv[0])
                vld_reg[0] <= in_valid;
            for (int s = 1; s <= Stages; s++)
                if (adv[s])
                    vld_reg[s] <= vld_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0] && in_valid)
        begin
            hrem_reg[0] <= in_word.hue_num;
            srem_reg[0] <= {1'b0, in_word.delta, 16'd0};
            dlt_reg[0]  <= in_word.delta;
            den_reg[0]  <= in_word.denom;
            lit_reg[0]  <= in_word.light;
        end
    end

    // Each register holds {remainder, pending numerator bits, quotient bits}
    // in place: classic shift-subtract over a fixed-width word.
    generate
        for (genvar s = 1; s <= Stages; s++)
        begin : g_stage
            logic [NumW-1:0]  h;
            logic [SatNumW:0] sv;
            always_comb
            begin
                h  = hrem_reg[s-1];
                sv = srem_reg[s-1];
                for (int k = 0; k < BitsPerStage; k++)
                begin
                    if ((s - 1) * BitsPerStage + k >= HueSkip
                        && (s - 1) * BitsPerStage + k < SatQW)
                        h = hstep(h, dlt_reg[s-1]);
                    if ((s - 1) * BitsPerStage + k < SatQW)
                        sv = sstep(sv, den_reg[s-1]);
                end
            end
            always_ff @(posedge clk)
            begin
                if (adv[s] && vld_reg[s-1])
                begin
                    hrem_reg[s] <= h;
                    srem_reg[s] <= sv;
                    dlt_reg[s]  <= dlt_reg[s-1];
                    den_reg[s]  <= den_reg[s-1];
                    lit_reg[s]  <= lit_reg[s-1];
                end
            end
        end
    endgenerate

    logic [SatQW-1:0] sq;
    assign sq = srem_reg[Stages][SatQW-1:0];

    assign out_valid  = vld_reg[Stages];
    assign hue        = (dlt_reg[Stages] == 8'd0) ? '0 : hrem_reg[Stages][HueQW-1:0];
    assign saturation = (dlt_reg[Stages] == 8'd0) ? '0
                      : (sq[SatQW-1] ? {SatW{1'b1}} : sq[SatW-1:0]);
    assign lightness  = lit_reg[Stages];

endmodule

/* verif/rgb_to_hsl_converter_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSL converter test
// Drives pixels through the valid/stall channel and compares each hsl word
// with an in-bench predictor, under phases of sender gaps and output stalls.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter_test;
    import rgbhsl_pkg::*;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pixel_t;

    typedef struct packed {
        logic [HueW-1:0] h;
        logic [SatW-1:0] s;
        logic [LitW-1:0] l;
    } hsl_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            valid = 1'b0;
    logic            stall;
    logic [7:0]      red = '0;
    logic [7:0]      green = '0;
    logic [7:0]      blue = '0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    logic [HueW-1:0] hue;
    logic [SatW-1:0] saturation;
    logic [LitW-1:0] lightness;

    pixel_t pending_px[$];
    hsl_t   expected_hsl[$];
    int     n_errors = 0;
    int     n_sent = 0;
    int     n_checked = 0;
    int     gap_pct = 0;
    int     stall_pct = 0;
    bit     hold_off = 1'b0;
    bit     driving = 1'b0;

    rgb_to_hsl_converter u_dut (.*);

    always #5 clk = ~clk;

    function automatic hsl_t convert_pixel(pixel_t p);
        int   r, g, b, hi, lo, d, n, den;
        int   q;
        sector_t sec;
        hsl_t o;
        r = p.r; g = p.g; b = p.b;
        hi = (r > g) ? r : g; hi = (hi > b) ? hi : b;
        lo = (r < g) ? r : g; lo = (lo < b) ? lo : b;
        d = hi - lo;
        o.l = LitW'(hi + lo);
        o.h = '0;
        o.s = '0;
        if (d != 0)
        begin
            // ties go green over red, blue over both
            if (r > g) sec = (r > b) ? SECT_RED : SECT_BLUE;
            else       sec = (g > b) ? SECT_GREEN : SECT_BLUE;
            case (sec)
                SECT_RED:   n = HueSector * (g - b);
                SECT_GREEN: n = HueSector * (b - r) + 2 * HueSector * d;
                default:    n = HueSector * (r - g) + 4 * HueSector * d;
            endcase
            if (n < 0) n += HueFull * d;
            o.h = HueW'(n / d);
            den = (hi + lo <= 255) ? hi + lo : 510 - (hi + lo);
            q = (d * 65536) / den;
            o.s = (q > 65535) ? 16'hFFFF : SatW'(q);
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        n_errors++;
    endtask

    // driver: at each falling edge, advance once the current word is taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!valid || driving)
            begin
                if (!hold_off && pending_px.size() > 0
                    && $urandom_range(99, 0) >= gap_pct)
                begin
                    pixel_t p;
                    p = pending_px.pop_front();
                    red <= p.r; green <= p.g; blue <= p.b;
                    valid <= 1'b1;
                end
                else
                    valid <= 1'b0;
            end
            out_stall <= ($urandom_range(99, 0) < stall_pct);
        end
    end

    // acceptance seen at the rising edge decides whether the driver may move on
    always @(posedge clk)
    begin
        driving <= rst_n && valid && !stall;
        if (rst_n && valid && !stall)
        begin
            expected_hsl.push_back(convert_pixel({red, green, blue}));
            n_sent++;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_hsl.size() == 0)
                report_mismatch("unexpected word", 0, 0);
            else
            begin
                hsl_t w;
                w = expected_hsl.pop_front();
                if (hue !== w.h) report_mismatch("hue", hue, w.h);
                if (saturation !== w.s) report_mismatch("saturation", saturation, w.s);
                if (lightness !== w.l) report_mismatch("lightness", lightness, w.l);
                n_checked++;
            end
        end
    end

    task automatic add_px(int r, int g, int b);
        pixel_t p;
        p.r = 8'(r); p.g = 8'(g); p.b = 8'(b);
        pending_px.push_back(p);
    endtask

    task automatic drain();
        while (pending_px.size() > 0 || valid || expected_hsl.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        int ph;
        int k;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // directed: gray, extremes, ties, each sector and red wrap
        add_px(0, 0, 0);       add_px(255, 255, 255); add_px(128, 128, 128);
        add_px(255, 0, 0);     add_px(0, 255, 0);     add_px(0, 0, 255);
        add_px(255, 255, 0);   add_px(0, 255, 255);   add_px(255, 0, 255);
        add_px(255, 0, 1);     add_px(200, 10, 200);  add_px(10, 200, 200);
        add_px(1, 0, 0);       add_px(254, 255, 255); add_px(255, 254, 254);
        add_px(0, 1, 1);       add_px(128, 127, 127); add_px(127, 128, 128);
        add_px(100, 50, 75);   add_px(170, 85, 85);   add_px(85, 170, 85);
        add_px(255, 128, 0);   add_px(1, 2, 3);
        drain();
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 54; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 54; end
                default: begin gap_pct = 19; stall_pct = 19; end
            endcase
            for (k = 0; k < 320; k++)
            begin
                case ($urandom_range(5, 0))
                    0: add_px($urandom_range(255, 0), $urandom_range(255, 0),
                              $urandom_range(255, 0));
                    1: begin int v; v = $urandom_range(255, 0); add_px(v, v, v); end
                    2: begin int v; v = $urandom_range(255, 0);
                              add_px(v, v, $urandom_range(255, 0)); end
                    3: begin int v; v = $urandom_range(255, 0);
                              add_px($urandom_range(255, 0), v, v); end
                    4: add_px($urandom_range(255, 250), $urandom_range(5, 0),
                              $urandom_range(255, 0));
                    default: add_px($urandom, $urandom, $urandom);
                endcase
            end
            if (ph == 1)
            begin
                // sender holds until the pipeline is empty
                while (pending_px.size() > 160) @(posedge clk);
                hold_off = 1'b1;
                while (valid || expected_hsl.size() > 0) @(posedge clk);
                hold_off = 1'b0;
            end
            drain();
        end
        stall_pct = 0;
        repeat (30) @(posedge clk);
        $display("sent %0d pixels, checked %0d words over four stall/gap phases",
                 n_sent, n_checked);
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
